// ===== hdl/lae_pkg.sv =====
package lae_pkg;

    // Item commands.
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_RUN   = 2'd2;

    // Configuration registers, selected by address bit 2.
    localparam logic REG_BOARD_SIZE = 1'b0;
    localparam logic REG_GEN_LIMIT  = 1'b1;

    localparam int PADDR_W     = 3;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    localparam logic [7:0]  BOARD_SIZE_RST = 8'd128;
    localparam logic [15:0] GEN_LIMIT_RST  = 16'd1;

    // Result item, packed so that cell_out lands in the lowest bit.
    typedef struct packed {
        logic        stable;
        logic [15:0] generations_done;
        logic        cell_out;
    } t_result;

endpackage

// ===== hdl/lae_row_unit.sv =====
// Computes one new board row from the old rows above, at and below it.
module lae_row_unit #(
    parameter int MAX_SIDE = 128,
    parameter int SIDE_W   = 8
) (
    input  logic [MAX_SIDE-1:0] i_up,
    input  logic [MAX_SIDE-1:0] i_md,
    input  logic [MAX_SIDE-1:0] i_dn,
    input  logic [SIDE_W-1:0]   i_side,
    output logic [MAX_SIDE-1:0] o_row,
    output logic                o_changed
);

    logic [MAX_SIDE-1:0] mask;
    logic [MAX_SIDE-1:0] up_m;
    logic [MAX_SIDE-1:0] md_m;
    logic [MAX_SIDE-1:0] dn_m;
    logic [MAX_SIDE-1:0] nx;

    always_comb begin
        for (int j = 0; j < MAX_SIDE; j++) begin
            mask[j] = (SIDE_W'(j) < i_side);
        end
    end

    assign up_m = i_up & mask;
    assign md_m = i_md & mask;
    assign dn_m = i_dn & mask;

    // Per-column neighbor count; columns beyond the board read as dead.
    always_comb begin
        logic [MAX_SIDE-1:0] ul;
        logic [MAX_SIDE-1:0] ur;
        logic [MAX_SIDE-1:0] ml;
        logic [MAX_SIDE-1:0] mr;
        logic [MAX_SIDE-1:0] dl;
        logic [MAX_SIDE-1:0] dr;
        logic [3:0]          cnt;
        ul = up_m << 1;
        ur = up_m >> 1;
        ml = md_m << 1;
        mr = md_m >> 1;
        dl = dn_m << 1;
        dr = dn_m >> 1;
        cnt = '0;
        for (int j = 0; j < MAX_SIDE; j++) begin
            cnt = {3'b000, ul[j]} + {3'b000, up_m[j]} + {3'b000, ur[j]}
                + {3'b000, ml[j]} + {3'b000, mr[j]}
                + {3'b000, dl[j]} + {3'b000, dn_m[j]} + {3'b000, dr[j]};
            nx[j] = mask[j] & ((cnt == 4'd3) | ((cnt == 4'd2) & md_m[j]));
        end
    end

    // Cells beyond the board keep their stored value.
    assign o_row     = (i_md & ~mask) | nx;
    assign o_changed = (nx != md_m);

endmodule

// ===== hdl/life_automaton_engine_unit.sv =====
// Sequence: a write or unused command is answered from the idle state, a read after its row is fetched
// into the read data register; each generation of a run loads two rows, then sweeps the board.
// Throughput: one item at a time; a run sweeps the board one row per cycle through one row unit.
// Reset (synchronous, active low) clears the handshake state, sets board_size to 128 and
// generation_limit to 1, then runs a clearing pass that writes every row dead; no item is
// taken during that pass, while configuration writes are taken as ever.
module life_automaton_engine_unit #(
    parameter int MAX_SIDE = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input items. tdata, from bit 0 up: command[1:0], row[8:2], col[15:9], cell_in[16].
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [lae_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // Result items. tdata, from bit 0 up: cell_out[0], generations_done[16:1], stable[17].
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [lae_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lae_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int IDX_W  = $clog2(MAX_SIDE);
    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int CW     = (SIDE_W > 8) ? SIDE_W : 8;

    // Sequencer states.
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_LOAD0 = 3'd3;
    localparam logic [2:0] ST_LOAD1 = 3'd4;
    localparam logic [2:0] ST_ROW   = 3'd5;
    localparam logic [2:0] ST_HOLD  = 3'd6;

    logic [2:0]  r_state, n_state;
    logic [7:0]  r_board_size;
    logic [15:0] r_gen_limit;
    logic [SIDE_W-1:0] r_row;
    logic        r_ovalid;
    lae_pkg::t_result r_out;
    lae_pkg::t_result r_res;
    lae_pkg::t_result res;

    logic [15:0] r_gen;
    logic        r_changed;
    logic [MAX_SIDE-1:0] r_up;
    logic [MAX_SIDE-1:0] r_md;
    logic [MAX_SIDE-1:0] r_rd_q;
    logic [IDX_W-1:0]    r_col;
    logic        r_inside;

    // The board store: one row of cells per entry.
    logic [MAX_SIDE-1:0] mem [MAX_SIDE];

    logic                bit_we;
    logic                row_we;
    logic [IDX_W-1:0]    waddr;
    logic [MAX_SIDE-1:0] wrow;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;

    logic        in_acc;
    logic [1:0]  in_cmd;
    logic [6:0]  in_row;
    logic [6:0]  in_col;
    logic        in_cell;
    logic        cfg_we;
    logic        emit;
    logic        out_ok;

    logic [CW-1:0]     board_cw;
    logic [CW-1:0]     side_cw;
    logic [SIDE_W-1:0] side;
    logic              on_board;
    logic [SIDE_W-1:0] row_p1;
    logic [SIDE_W-1:0] row_p2;
    logic              last_row;
    logic [MAX_SIDE-1:0] dn_eff;
    logic [MAX_SIDE-1:0] unit_row;
    logic              unit_changed;
    logic              chg_all;
    logic [15:0]       gen_inc;

    assign in_cmd  = s_axis_tdata[1:0];
    assign in_row  = s_axis_tdata[8:2];
    assign in_col  = s_axis_tdata[15:9];
    assign in_cell = s_axis_tdata[16];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {{(lae_pkg::OUT_TDATA_W - $bits(lae_pkg::t_result)){1'b0}}, r_out};
    assign out_ok        = !r_ovalid || m_axis_tready;

    // Configuration registers: address bit 2 picks the register.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_comb begin
        if (paddr[2] == lae_pkg::REG_BOARD_SIZE) begin
            prdata = {24'd0, r_board_size};
        end else begin
            prdata = {16'd0, r_gen_limit};
        end
    end

    // Side in use: a board size of zero acts as one, a size above MAX_SIDE as MAX_SIDE.
    assign board_cw = CW'(r_board_size);
    always_comb begin
        if (board_cw == '0) begin
            side_cw = CW'(1);
        end else if (board_cw > CW'(MAX_SIDE)) begin
            side_cw = CW'(MAX_SIDE);
        end else begin
            side_cw = board_cw;
        end
    end
    assign side     = SIDE_W'(side_cw);
    assign on_board = (CW'(in_row) < side_cw) && (CW'(in_col) < side_cw);

    // Row sweep: r_up and r_md hold the old rows above and at the current row, and the
    // read data register holds the old row below it, fetched in the previous cycle.
    assign row_p1   = r_row + SIDE_W'(1);
    assign row_p2   = r_row + SIDE_W'(2);
    assign last_row = (row_p1 == side);
    assign dn_eff   = (row_p1 < side) ? r_rd_q : '0;

    lae_row_unit #(
        .MAX_SIDE (MAX_SIDE),
        .SIDE_W   (SIDE_W)
    ) u_row_unit (
        .i_up      (r_up),
        .i_md      (r_md),
        .i_dn      (dn_eff),
        .i_side    (side),
        .o_row     (unit_row),
        .o_changed (unit_changed)
    );

    assign chg_all = r_changed | unit_changed;
    assign gen_inc = r_gen + 16'd1;

    always_comb begin
        n_state = r_state;
        emit    = 1'b0;
        res     = '0;
        bit_we  = 1'b0;
        row_we  = 1'b0;
        waddr   = '0;
        wrow    = '0;
        rd_en   = 1'b0;
        rd_addr = '0;
        case (r_state)
            ST_CLEAR: begin
                row_we = 1'b1;
                waddr  = r_row[IDX_W-1:0];
                if (r_row == SIDE_W'(MAX_SIDE - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    case (in_cmd)
                        lae_pkg::CMD_WRITE: begin
                            bit_we = on_board;
                            waddr  = IDX_W'(in_row);
                            emit   = 1'b1;
                        end
                        lae_pkg::CMD_READ: begin
                            rd_en   = 1'b1;
                            rd_addr = IDX_W'(in_row);
                            n_state = ST_READ;
                        end
                        lae_pkg::CMD_RUN: begin
                            if (r_gen_limit == 16'd0) begin
                                emit = 1'b1;
                            end else begin
                                n_state = ST_LOAD0;
                            end
                        end
                        default: begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                emit         = 1'b1;
                res.cell_out = r_inside & r_rd_q[r_col];
            end
            ST_LOAD0: begin
                rd_en   = 1'b1;
                n_state = ST_LOAD1;
            end
            ST_LOAD1: begin
                rd_en   = 1'b1;
                rd_addr = IDX_W'(1);
                n_state = ST_ROW;
            end
            ST_ROW: begin
                row_we  = 1'b1;
                waddr   = r_row[IDX_W-1:0];
                wrow    = unit_row;
                rd_en   = (row_p2 < side);
                rd_addr = row_p2[IDX_W-1:0];
                if (last_row) begin
                    res.generations_done = gen_inc;
                    if (!chg_all) begin
                        emit       = 1'b1;
                        res.stable = 1'b1;
                    end else if (gen_inc == r_gen_limit) begin
                        emit = 1'b1;
                    end else begin
                        n_state = ST_LOAD0;
                    end
                end
            end
            ST_HOLD: begin
                emit = 1'b1;
                res  = r_res;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        // A finished result goes straight to the output register when it is free, else it
        // waits in the hold register.
        if (emit) begin
            n_state = out_ok ? ST_IDLE : ST_HOLD;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_row        <= '0;
            r_ovalid     <= 1'b0;
            r_board_size <= lae_pkg::BOARD_SIZE_RST;
            r_gen_limit  <= lae_pkg::GEN_LIMIT_RST;
        end else begin
            r_state <= n_state;
            if (cfg_we) begin
                if (paddr[2] == lae_pkg::REG_BOARD_SIZE) begin
                    r_board_size <= pwdata[7:0];
                end else begin
                    r_gen_limit <= pwdata[15:0];
                end
            end
            case (r_state)
                ST_CLEAR: r_row <= r_row + SIDE_W'(1);
                ST_LOAD1: r_row <= '0;
                ST_ROW:   r_row <= row_p1;
                default:  r_row <= r_row;
            endcase
            if (emit && out_ok) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Payload and working registers.
    always_ff @(posedge i_clk) begin
        if (emit && out_ok) begin
            r_out <= res;
        end
        if (emit && !out_ok) begin
            r_res <= res;
        end
        if (in_acc) begin
            r_col    <= IDX_W'(in_col);
            r_inside <= on_board;
            r_gen    <= '0;
        end
        case (r_state)
            ST_LOAD1: begin
                r_up      <= '0;
                r_md      <= r_rd_q;
                r_changed <= 1'b0;
            end
            ST_ROW: begin
                r_up      <= r_md;
                r_md      <= dn_eff;
                r_changed <= chg_all;
                if (last_row) begin
                    r_gen <= gen_inc;
                end
            end
            default: begin
                r_changed <= r_changed;
            end
        endcase
    end

    // Board store: one write (a single cell or a whole row) and one registered read a cycle.
    always_ff @(posedge i_clk) begin
        if (bit_we) begin
            mem[waddr][IDX_W'(in_col)] <= in_cell;
        end else if (row_we) begin
            mem[waddr] <= wrow;
        end
        if (rd_en) begin
            r_rd_q <= mem[rd_addr];
        end
    end

endmodule
